>>> rtl/rrfr_pkg.sv
// ----------------------------------------------------------------------------
// rrfr_pkg: shared constants for the receive ring frame reader
// Ring geometry, header layout, record kinds and register map.
// ----------------------------------------------------------------------------
package rrfr_pkg;

	// ring geometry
	localparam int RING_BYTES = 65536;
	localparam int POS_W      = $clog2(RING_BYTES);

	// frame layout
	localparam int OFF_W       = 17;
	localparam int HDR_BYTES   = 4;
	localparam int OK_BIT      = 0;
	localparam int PTR_BACKOFF = 16;
	localparam logic [OFF_W-1:0] ALIGN_MASK = ~(OFF_W'(3));
	localparam logic [OFF_W-1:0] MAX_SPAN   = OFF_W'(65540);

	// record kinds
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_DONE    = 1'b1;

	// register map
	localparam int PADDR_W = 3;
	localparam logic REG_COPY_LIMIT = 1'b0;
	localparam logic [15:0] COPY_LIMIT_RESET = 16'd1800;

endpackage

>>> rtl/rrfr_in_if.sv
// ----------------------------------------------------------------------------
// rrfr_in_if: ring byte channel
// Carries one ring byte per word with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface rrfr_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> rtl/rrfr_out_if.sv
// ----------------------------------------------------------------------------
// rrfr_out_if: result channel
// Carries payload bytes and frame done records with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface rrfr_out_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [7:0]  data_byte;
	logic        frame_ok;
	logic [15:0] delivered_count;
	logic [15:0] read_pointer;

	modport source (output valid, output kind, output data_byte, output frame_ok,
		output delivered_count, output read_pointer, input ready);
	modport sink   (input valid, input kind, input data_byte, input frame_ok,
		input delivered_count, input read_pointer, output ready);
endinterface

>>> rtl/rx_ring_frame_reader_top.sv
// ----------------------------------------------------------------------------
// rx_ring_frame_reader_top: receive ring frame reader
// Parses frames from a byte stream of the receive ring and emits payload
// bytes and one done record per frame.
// ----------------------------------------------------------------------------
// Usage
//   in_ch  : ring bytes in ring order, one per word.
//   out_ch : payload words (kind 0) and frame done records (kind 1) carrying
//            the ok flag, bytes delivered and the updated read pointer.
//   APB    : copy_limit at byte address 0; writes only while idle.
// Timing
//   one byte per cycle while out_ch keeps taking results; a byte goes into
//   an input register, is parsed there against the frame state and its
//   result lands in the result register, from which out_ch takes it.
//   The parse step is a single pass of compare/increment logic on the frame
//   offset, so it does not hold the rate below one byte per clock.
// Reset
//   ring position, frame offset and counts clear; copy_limit returns to 1800.
// Stall
//   while out_ch is stalled the result register holds; one more byte may sit
//   in the input register, then in_ch.ready drops until the result is taken.
// ----------------------------------------------------------------------------
module rx_ring_frame_reader_top
	import rrfr_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	rrfr_in_if.sink            in_ch,
	rrfr_out_if.source         out_ch,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic [15:0]      copy_limit_q;
	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic [POS_W-1:0] pos_q;
	logic [OFF_W-1:0] off_q;
	logic             ok_q;
	logic [15:0]      len_q;
	logic [15:0]      sent_q;

	logic             res_valid_q;
	logic             res_kind_q;
	logic [7:0]       res_data_q;
	logic             res_ok_q;
	logic [15:0]      res_count_q;
	logic [15:0]      res_rp_q;

	logic             res_free;
	logic             proc;
	logic [15:0]      length;
	logic             frame_ok;
	logic [OFF_W-1:0] span;
	logic [OFF_W:0]   off_inc;
	logic             hdr_done;
	logic             payload;
	logic             done;
	logic [POS_W-1:0] pos_next;
	logic [POS_W-1:0] rp;

	// configuration port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_COPY_LIMIT) ? {16'd0, copy_limit_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			copy_limit_q <= COPY_LIMIT_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_COPY_LIMIT) begin
			copy_limit_q <= pwdata[15:0];
		end
	end

	// handshake
	assign res_free    = !res_valid_q || out_ch.ready;
	assign proc        = valid_s1 && res_free;
	assign in_ch.ready = !valid_s1 || res_free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			byte_s1 <= in_ch.rx_byte;
		end
	end

	// header fields, the length high byte arriving with the last header byte
	assign length   = (off_q == OFF_W'(HDR_BYTES - 1)) ? {byte_s1, len_q[7:0]} : len_q;
	assign frame_ok = ok_q;
	assign span     = (OFF_W'(length) + OFF_W'(HDR_BYTES + 3)) & ALIGN_MASK;
	assign off_inc  = {1'b0, off_q} + 1'b1;
	assign hdr_done = off_q >= OFF_W'(HDR_BYTES - 1);

	// payload and end of frame decisions
	assign payload = (off_q >= OFF_W'(HDR_BYTES)) && (off_q < OFF_W'(length)) && frame_ok
		&& (sent_q < copy_limit_q);
	assign done    = hdr_done && (off_inc >= {1'b0, span});

	// ring position and backed-off read pointer
	assign pos_next = (pos_q == POS_W'(RING_BYTES - 1)) ? '0 : pos_q + 1'b1;
	assign rp = (pos_next >= POS_W'(PTR_BACKOFF)) ? pos_next - POS_W'(PTR_BACKOFF)
		: pos_next + POS_W'(RING_BYTES - PTR_BACKOFF);

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			off_q  <= '0;
			ok_q   <= 1'b0;
			len_q  <= '0;
			sent_q <= '0;
		end else if (proc) begin
			pos_q <= pos_next;
			if (off_q == OFF_W'(0)) begin
				ok_q <= byte_s1[OK_BIT];
			end
			if (off_q == OFF_W'(2)) begin
				len_q[7:0] <= byte_s1;
			end
			if (off_q == OFF_W'(3)) begin
				len_q[15:8] <= byte_s1;
			end
			if (done) begin
				off_q  <= '0;
				sent_q <= '0;
			end else begin
				off_q <= off_inc[OFF_W-1:0];
				if (payload) begin
					sent_q <= sent_q + 1'b1;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_free) begin
			res_valid_q <= proc && (payload || done);
		end
	end

	always_ff @(posedge clk) begin
		if (proc && res_free) begin
			if (done) begin
				res_kind_q  <= KIND_DONE;
				res_data_q  <= 8'd0;
				res_ok_q    <= frame_ok;
				res_count_q <= frame_ok ? sent_q : 16'd0;
				res_rp_q    <= 16'(rp);
			end else begin
				res_kind_q  <= KIND_PAYLOAD;
				res_data_q  <= byte_s1;
				res_ok_q    <= 1'b0;
				res_count_q <= 16'd0;
				res_rp_q    <= 16'd0;
			end
		end
	end

	assign out_ch.valid           = res_valid_q;
	assign out_ch.kind            = res_kind_q;
	assign out_ch.data_byte       = res_data_q;
	assign out_ch.frame_ok        = res_ok_q;
	assign out_ch.delivered_count = res_count_q;
	assign out_ch.read_pointer    = res_rp_q;

	// checks
	a_off_bound: assert property (@(posedge clk) disable iff (!arst_n)
		off_q < MAX_SPAN)
		else $error("frame offset beyond largest frame span");

	a_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_kind_q == KIND_PAYLOAD) |->
		(!res_ok_q && res_count_q == 16'd0 && res_rp_q == 16'd0))
		else $error("payload word carries done record fields");

	a_rp_range: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_kind_q == KIND_DONE) |->
		(32'(res_rp_q) < RING_BYTES && res_data_q == 8'd0))
		else $error("done record read pointer outside ring");

	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && payload && !done) |=> (sent_q != 16'd0))
		else $error("delivered count did not advance");

endmodule

>>> bench/tb_rx_ring_frame_reader_top.sv
// ----------------------------------------------------------------------------
// tb_rx_ring_frame_reader_top: bench for the receive ring frame reader
// Feeds ring bytes built from well-formed frames with random content, tracks
// the frame state alongside the block and checks every payload word and done
// record in order. Covers copy limit extremes, a long good frame, bad
// frames, random idling on both sides and a long output stall.
// ----------------------------------------------------------------------------
module tb_rx_ring_frame_reader_top;
	import rrfr_pkg::*;

	// one output word as seen on out_ch
	typedef struct packed {
		logic        kind;
		logic [7:0]  data_byte;
		logic        frame_ok;
		logic [15:0] delivered_count;
		logic [15:0] read_pointer;
	} reader_word_t;

	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;
	typedef enum int {CHK_MODEL, CHK_NONE, CHK_LIT} row_chk_e;

	typedef struct {
		logic [7:0]   rx_byte;
		row_chk_e     chk;
		reader_word_t lit;
	} dir_row_t;

	localparam int DIR_N         = 24;
	localparam int SETTLE_CYCLES = 6;
	localparam logic [PADDR_W-1:0] COPY_LIMIT_ADDR = PADDR_W'(4 * int'(REG_COPY_LIMIT));

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	rrfr_in_if  in_ch ();
	rrfr_out_if out_ch ();

	rx_ring_frame_reader_top uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// tracked frame state
	logic [POS_W-1:0] trk_pos;
	logic [OFF_W-1:0] trk_off;
	logic [31:0]      trk_hdr;
	logic [15:0]      trk_sent;
	logic [15:0]      trk_limit;

	reader_word_t reader_words_q[$];
	logic [7:0]   ring_stream_q[$];
	idle_mode_e   idle_mode = IDLE_NONE;
	int           hold_left = 0;
	int           mismatch_cnt = 0;
	dir_row_t     dir_rows [DIR_N];

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// timeout
	initial begin
		#15_000_000;
		$display("TB_ERROR");
		$finish;
	end

	task automatic log_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		mismatch_cnt++;
	endtask

	// track one accepted ring byte, giving the word it causes if any
	function automatic void parse_ring_byte(input logic [7:0] b, output bit has,
		output reader_word_t word);
		logic [OFF_W-1:0] off;
		logic [15:0]      status;
		logic [15:0]      length;
		logic [OFF_W-1:0] span;
		logic             ok;
		off  = trk_off;
		has  = 1'b0;
		word = '0;
		if (off < HDR_BYTES)
			trk_hdr = trk_hdr | (32'(b) << (8 * off));
		trk_pos = (trk_pos == POS_W'(RING_BYTES - 1)) ? '0 : trk_pos + 1'b1;
		if (off + 1 < HDR_BYTES) begin
			trk_off = off + 1'b1;
			return;
		end
		status = trk_hdr[15:0];
		length = trk_hdr[31:16];
		ok     = status[OK_BIT];
		span   = (OFF_W'(length) + OFF_W'(HDR_BYTES + 3)) & ALIGN_MASK;
		// payload byte while under the copy limit
		if (off >= HDR_BYTES && off < OFF_W'(length) && ok && trk_sent < trk_limit) begin
			word = '{KIND_PAYLOAD, b, 1'b0, 16'd0, 16'd0};
			trk_sent = trk_sent + 1'b1;
			has = 1'b1;
		end
		// last byte of the span closes the frame
		if (off + 1 >= span) begin
			word = '{KIND_DONE, 8'h00, ok, ok ? trk_sent : 16'd0,
				16'(trk_pos - POS_W'(PTR_BACKOFF))};
			has = 1'b1;
			trk_off  = '0;
			trk_hdr  = '0;
			trk_sent = '0;
			return;
		end
		trk_off = off + 1'b1;
	endfunction

	// sender gap length for the current idle mode
	function automatic int sender_gap();
		int pct;
		int gap;
		pct = (idle_mode == IDLE_SEND) ? 65 : (idle_mode == IDLE_BOTH) ? 30 : 0;
		gap = 0;
		while (gap < 200 && $urandom_range(99) < pct)
			gap++;
		return gap;
	endfunction

	// offer one byte and wait for it to be taken
	task automatic present_byte(input logic [7:0] b);
		int gap;
		gap = sender_gap();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid   <= 1'b1;
		in_ch.rx_byte <= b;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
	endtask

	task automatic offer_byte(input logic [7:0] b);
		bit has;
		reader_word_t word;
		present_byte(b);
		parse_ring_byte(b, has, word);
		if (has)
			reader_words_q.push_back(word);
	endtask

	task automatic stop_offering();
		in_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// one frame into the stream; forced_len below zero picks a random length
	task automatic build_frame(input int forced_len, input bit force_ok);
		int len;
		int span;
		int pick;
		logic [15:0] st;
		pick = $urandom_range(99);
		if (forced_len >= 0)
			len = forced_len;
		else if (pick < 10)
			len = $urandom_range(0, 4);
		else if (pick < 92)
			len = $urandom_range(5, 48);
		else
			len = $urandom_range(49, 300);
		st = 16'($urandom);
		st[OK_BIT] = force_ok || ($urandom_range(99) < 80);
		ring_stream_q.push_back(st[7:0]);
		ring_stream_q.push_back(st[15:8]);
		ring_stream_q.push_back(8'(len));
		ring_stream_q.push_back(8'(len >> 8));
		span = (len + HDR_BYTES + 3) & ~3;
		for (int i = HDR_BYTES; i < span; i++)
			ring_stream_q.push_back(8'($urandom));
	endtask

	task automatic run_phase(input idle_mode_e mode, input int n_bytes);
		logic [7:0] b;
		idle_mode = mode;
		for (int i = 0; i < n_bytes; i++) begin
			if (ring_stream_q.size() == 0)
				build_frame(-1, 1'b0);
			b = ring_stream_q.pop_front();
			offer_byte(b);
		end
	endtask

	task automatic flush_stream();
		logic [7:0] b;
		while (ring_stream_q.size() != 0) begin
			b = ring_stream_q.pop_front();
			offer_byte(b);
		end
	endtask

	// apb transfers, each starting on a fresh edge
	task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic apb_read(input logic [PADDR_W-1:0] addr, output logic [31:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= addr;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		data     = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_copy_limit(input logic [15:0] val);
		logic [31:0] rd;
		apb_read(COPY_LIMIT_ADDR, rd);
		if (rd !== {16'h0000, val})
			log_mismatch($sformatf("copy_limit read %h, wanted %h", rd, val));
	endtask

	// new copy limit once the block has gone quiet
	task automatic load_copy_limit(input logic [15:0] val);
		stop_offering();
		while (reader_words_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		apb_write(COPY_LIMIT_ADDR, {16'h0000, val});
		trk_limit = val;
		check_copy_limit(val);
	endtask

	// output side: check each taken word, then pick the next ready
	always @(posedge clk) begin
		reader_word_t got;
		reader_word_t want;
		int pct;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				got = {out_ch.kind, out_ch.data_byte, out_ch.frame_ok,
					out_ch.delivered_count, out_ch.read_pointer};
				if (reader_words_q.size() == 0) begin
					log_mismatch($sformatf("unexpected word %h", got));
				end else begin
					want = reader_words_q.pop_front();
					if (got !== want)
						log_mismatch($sformatf("word %h, wanted %h", got, want));
				end
			end
			pct = (idle_mode == IDLE_RECV) ? 65 : (idle_mode == IDLE_BOTH) ? 30 : 0;
			if (hold_left > 0) begin
				out_ch.ready <= 1'b0;
				hold_left = hold_left - 1;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= pct);
			end
		end else begin
			out_ch.ready <= 1'b0;
		end
	end

	// main sequence
	initial begin
		bit has;
		reader_word_t word;
		arst_n        <= 1'b0;
		in_ch.valid   <= 1'b0;
		in_ch.rx_byte <= 8'h00;
		psel          <= 1'b0;
		penable       <= 1'b0;
		pwrite        <= 1'b0;
		paddr         <= '0;
		pwdata        <= '0;
		trk_pos   = '0;
		trk_off   = '0;
		trk_hdr   = '0;
		trk_sent  = '0;
		trk_limit = COPY_LIMIT_RESET;

		// zero-length bad frame, short good frame, bad frame with length below five
		dir_rows = '{
			'{8'h00, CHK_NONE,  '0},
			'{8'h00, CHK_NONE,  '0},
			'{8'h00, CHK_NONE,  '0},
			'{8'h00, CHK_LIT,   '{KIND_DONE, 8'h00, 1'b0, 16'd0, 16'hFFF4}},
			'{8'h01, CHK_NONE,  '0},
			'{8'h00, CHK_NONE,  '0},
			'{8'h06, CHK_NONE,  '0},
			'{8'h00, CHK_NONE,  '0},
			'{8'h00, CHK_LIT,   '{KIND_PAYLOAD, 8'h00, 1'b0, 16'd0, 16'd0}},
			'{8'hFF, CHK_LIT,   '{KIND_PAYLOAD, 8'hFF, 1'b0, 16'd0, 16'd0}},
			'{8'hA5, CHK_NONE,  '0},
			'{8'h5A, CHK_NONE,  '0},
			'{8'hFF, CHK_NONE,  '0},
			'{8'h00, CHK_NONE,  '0},
			'{8'h3C, CHK_NONE,  '0},
			'{8'hC3, CHK_LIT,   '{KIND_DONE, 8'h00, 1'b1, 16'd2, 16'h0000}},
			'{8'hFE, CHK_NONE,  '0},
			'{8'hFF, CHK_NONE,  '0},
			'{8'h01, CHK_NONE,  '0},
			'{8'h00, CHK_NONE,  '0},
			'{8'h11, CHK_MODEL, '0},
			'{8'h22, CHK_MODEL, '0},
			'{8'h33, CHK_MODEL, '0},
			'{8'h44, CHK_LIT,   '{KIND_DONE, 8'h00, 1'b0, 16'd0, 16'h0008}}
		};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_copy_limit(COPY_LIMIT_RESET);

		// directed table
		idle_mode = IDLE_NONE;
		for (int i = 0; i < DIR_N; i++) begin
			present_byte(dir_rows[i].rx_byte);
			parse_ring_byte(dir_rows[i].rx_byte, has, word);
			case (dir_rows[i].chk)
				CHK_LIT:   reader_words_q.push_back(dir_rows[i].lit);
				CHK_MODEL: if (has) reader_words_q.push_back(word);
				default: ;
			endcase
		end

		// random phases, limit changes landing mid-frame
		load_copy_limit(16'd1800);
		run_phase(IDLE_NONE, 80);
		load_copy_limit(16'd0);
		run_phase(IDLE_SEND, 80);
		load_copy_limit(16'd5);
		run_phase(IDLE_RECV, 90);

		// long output stall while bytes keep coming
		load_copy_limit(16'hFFFF);
		hold_left = 300;
		run_phase(IDLE_BOTH, 90);

		// pause the sender until everything has drained
		load_copy_limit(16'($urandom_range(0, 20)));
		run_phase(IDLE_SEND, 50);
		stop_offering();
		while (reader_words_q.size() != 0)
			@(posedge clk);
		run_phase(IDLE_SEND, 50);

		// long good frame with a length of 100 bytes
		load_copy_limit(16'hFFFF);
		idle_mode = IDLE_NONE;
		flush_stream();
		build_frame(100, 1'b1);
		flush_stream();

		load_copy_limit(16'd1800);
		run_phase(IDLE_BOTH, 30);

		// wind down
		stop_offering();
		idle_mode = IDLE_NONE;
		while (reader_words_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
